// ===== rtl/assert_macros.svh =====
// Assertion macros used by the pad multiplexer core RTL.
// Needs a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SBPM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pad multiplexer check failed");

// Next-cycle implication.
`define SBPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pad multiplexer check failed");

`endif

// ===== rtl/sbpm_pkg.sv =====
// Types, constants and the pad line multiplexer for the pad multiplexer.
// No dependencies.
package sbpm_pkg;

  localparam int PADDR_W = 3;

  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_SELECT = 3'd1;
  localparam logic [2:0] KIND_READ   = 3'd2;
  localparam logic [2:0] KIND_BUTTON = 3'd3;
  localparam logic [2:0] KIND_PLUG   = 3'd4;

  localparam logic REG_TIMEOUT = 1'b0;

  localparam logic [11:0] ALL_RELEASED  = 12'hfff;
  localparam logic [16:0] ELAPSED_MAX   = 17'h1ffff;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1500;
  localparam logic [2:0]  MASK_SIX      = 3'd7;
  localparam logic [2:0]  MASK_THREE    = 3'd1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  select_byte;
    logic [11:0] press_mask;
    logic [11:0] release_mask;
  } item_t;

  function automatic logic [5:0] pad_lines(input logic [11:0] s, input logic [2:0] ph);
    logic [5:0] r;
    case (ph)
      3'd1, 3'd3: r = {s[7], s[4], 2'b00, s[1:0]};
      3'd5:       r = {s[7], s[4], 4'b0000};
      3'd6:       r = {s[6], s[5], s[11], s[8], s[9], s[10]};
      3'd7:       r = {s[7], s[4], 4'b1111};
      default:    r = {s[6], s[5], s[3:0]};
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/six_button_pad_multiplexer_unit.sv =====
// Six-button game pad multiplexer, top level.
// Input channel: kind, select_byte, press_mask, release_mask with in_valid
// and in_stall; a word is taken at an edge with in_valid high, in_stall low.
// Output channel: read_data with out_valid and out_stall; only a read item
// yields a word; other kinds yield nothing, and spare kinds change no state.
// A read is held in the input register, then its word in the output register.
// Throughput: one item per cycle. The input register feeds the state update
// directly; only a read waiting behind a stalled, full output register holds
// the input register, and in_stall rises for that time.
// While out_stall is high the output word holds; non-read items keep flowing.
// The timeout register sits at byte address 0 of the APB-style port, which
// may be written only while the block is idle.
// Reset (rst, synchronous): all buttons released, phase zero, six-button
// mode, tick count zero, timeout 1500, both channels empty.
// Depends on sbpm_pkg, sbpm_apb and sbpm_core.
module six_button_pad_multiplexer_unit import sbpm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         kind,
  input  logic [7:0]         select_byte,
  input  logic [11:0]        press_mask,
  input  logic [11:0]        release_mask,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         read_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic        item_valid;
  item_t       item;
  logic        item_go;
  logic [15:0] timeout_ticks;

  assign in_stall = item_valid && !item_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid <= 1'b1;
    end else if (item_go) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= '{kind: kind, select_byte: select_byte,
                press_mask: press_mask, release_mask: release_mask};
    end
  end

  sbpm_apb u_apb (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .timeout_ticks (timeout_ticks)
  );

  sbpm_core u_core (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item          (item),
    .timeout_ticks (timeout_ticks),
    .item_go       (item_go),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .read_data     (read_data)
  );

endmodule

// ===== rtl/sbpm_apb.sv =====
// APB-style configuration port holding the phase timeout register.
// Depends on sbpm_pkg.
module sbpm_apb import sbpm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic [15:0]        timeout_ticks
);

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_TIMEOUT) begin
      timeout_ticks <= pwdata[15:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TIMEOUT) ? {16'h0000, timeout_ticks} : 32'h0;

endmodule

// ===== rtl/sbpm_core.sv =====
// Pad state update and registered read result.
// Depends on sbpm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sbpm_core import sbpm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  item_t       item,
  input  logic [15:0] timeout_ticks,
  output logic        item_go,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  read_data
);

  logic [11:0] button_bits, button_bits_next;
  logic [2:0]  phase, phase_next;
  logic [2:0]  phase_mask, phase_mask_next;
  logic [16:0] elapsed_ticks, elapsed_ticks_next;
  logic [2:0]  phase_chk;
  logic        is_read;

  assign is_read   = (item.kind == KIND_READ);
  assign item_go   = item_valid && (!is_read || !out_valid || !out_stall);
  assign phase_chk = (elapsed_ticks > {1'b0, timeout_ticks}) ? 3'd0 : phase;

  always_comb begin
    button_bits_next   = button_bits;
    phase_next         = phase;
    phase_mask_next    = phase_mask;
    elapsed_ticks_next = elapsed_ticks;
    case (item.kind)
      KIND_TICK: begin
        if (elapsed_ticks != ELAPSED_MAX) elapsed_ticks_next = elapsed_ticks + 17'd1;
      end
      KIND_SELECT: begin
        elapsed_ticks_next = '0;
        if (item.select_byte[2] != phase_chk[0]) phase_next = (phase_chk + 3'd1) & phase_mask;
        else phase_next = phase_chk;
      end
      KIND_READ: begin
        phase_next = phase_chk;
      end
      KIND_BUTTON: begin
        button_bits_next = (button_bits & ~item.press_mask) | item.release_mask;
      end
      KIND_PLUG: begin
        phase_mask_next  = button_bits[11] ? MASK_SIX : MASK_THREE;
        button_bits_next = ALL_RELEASED;
        phase_next       = 3'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      button_bits   <= ALL_RELEASED;
      phase         <= 3'd0;
      phase_mask    <= MASK_SIX;
      elapsed_ticks <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (item_go) begin
        button_bits   <= button_bits_next;
        phase         <= phase_next;
        phase_mask    <= phase_mask_next;
        elapsed_ticks <= elapsed_ticks_next;
      end
      if (item_go && is_read) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_go && is_read) read_data <= pad_lines(button_bits, phase_chk);
  end

  `SBPM_ASSERT_SAME(a_mask_legal, 1'b1, phase_mask == MASK_SIX || phase_mask == MASK_THREE)
  `SBPM_ASSERT_SAME(a_phase_in_mask, phase_mask == MASK_THREE, phase[2:1] == 2'b00)
  `SBPM_ASSERT_NEXT(a_read_gives_word, item_go && is_read, out_valid)
  `SBPM_ASSERT_NEXT(a_plug_clears, item_go && item.kind == KIND_PLUG,
                    button_bits == ALL_RELEASED && phase == 3'd0)

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for six_button_pad_multiplexer_unit: a directed table, then random
// pad traffic, every read word checked against an in-bench predictor or a table value.
// Depends on sbpm_pkg and the RTL of the unit.
module tb_top;
  import sbpm_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam logic [PADDR_W-1:0] TIMEOUT_ADDR = PADDR_W'(4 * REG_TIMEOUT);
  localparam logic [2:0] KIND_SPARE_5 = 3'd5;
  localparam logic [2:0] KIND_SPARE_7 = 3'd7;
  localparam logic [11:0] MODE_BUTTON = 12'h800;
  localparam int N_ROWS = 27;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  sel;
    logic [11:0] press;
    logic [11:0] rel;
    logic        fixed_on;
    logic [5:0]  fixed_val;
  } pad_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] kind = '0;
  logic [7:0] select_byte = '0;
  logic [11:0] press_mask = '0;
  logic [11:0] release_mask = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [5:0] read_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // predictor state
  logic [11:0] buttons_q = ALL_RELEASED;
  logic [2:0]  phase_q = '0;
  logic [2:0]  mask_q = MASK_SIX;
  logic [16:0] ticks_q = '0;
  logic [15:0] timeout_q = TIMEOUT_RESET;

  logic [5:0] pad_words_due[$];
  pad_row_t   pad_rows[N_ROWS];
  int errors = 0;
  int words_seen = 0;
  int items_sent = 0;
  int cycles = 0;
  int stall_left = 0;
  bit quiet = 1'b0;
  logic [15:0] timeout_mid;

  six_button_pad_multiplexer_unit dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, pad_words_due.size());
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 16) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      words_seen++;
      if (pad_words_due.size() == 0) begin
        report_mismatch($sformatf("read_data %h with no read pending", read_data));
      end else begin
        logic [5:0] want;
        want = pad_words_due.pop_front();
        if (read_data !== want)
          report_mismatch($sformatf("read_data %h, want %h", read_data, want));
      end
    end
  end

  function automatic logic [5:0] pad_word();
    logic [11:0] b;
    b = buttons_q;
    case (phase_q)
      3'd1, 3'd3: return {b[7], b[4], 2'b00, b[1], b[0]};
      3'd5:       return {b[7], b[4], 4'b0000};
      3'd6:       return {b[6], b[5], b[11], b[8], b[9], b[10]};
      3'd7:       return {b[7], b[4], 4'b1111};
      default:    return {b[6], b[5], b[3:0]};
    endcase
  endfunction

  task automatic step_pad(input item_t it, output bit has_word, output logic [5:0] word);
    has_word = 1'b0;
    word = '0;
    case (it.kind)
      KIND_TICK: begin
        if (ticks_q != ELAPSED_MAX) ticks_q = ticks_q + 17'd1;
      end
      KIND_SELECT: begin
        if (ticks_q > {1'b0, timeout_q}) phase_q = '0;
        ticks_q = '0;
        if (it.select_byte[2] != phase_q[0]) phase_q = (phase_q + 3'd1) & mask_q;
      end
      KIND_READ: begin
        if (ticks_q > {1'b0, timeout_q}) phase_q = '0;
        has_word = 1'b1;
        word = pad_word();
      end
      KIND_BUTTON: begin
        buttons_q = (buttons_q & ~it.press_mask) | it.release_mask;
      end
      KIND_PLUG: begin
        mask_q = ((buttons_q & MODE_BUTTON) != 0) ? MASK_SIX : MASK_THREE;
        buttons_q = ALL_RELEASED;
        phase_q = '0;
      end
      default: ;
    endcase
  endtask

  task automatic push_item(input item_t it, input bit fixed_on, input logic [5:0] fixed_val);
    bit has_word;
    logic [5:0] word;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= it.kind;
    select_byte <= it.select_byte;
    press_mask <= it.press_mask;
    release_mask <= it.release_mask;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    step_pad(it, has_word, word);
    if (has_word) pad_words_due.insert(pad_words_due.size(), fixed_on ? fixed_val : word);
  endtask

  task automatic send(input logic [2:0] k, input logic [7:0] s, input logic [11:0] p,
                      input logic [11:0] r);
    item_t it;
    it.kind = k;
    it.select_byte = s;
    it.press_mask = p;
    it.release_mask = r;
    push_item(it, 1'b0, '0);
  endtask

  task automatic set_timeout(input logic [15:0] value);
    in_valid <= 1'b0;
    while (pad_words_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= TIMEOUT_ADDR;
    pwdata <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    timeout_q = value;
  endtask

  task automatic random_traffic(input int n);
    logic [7:0] s;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      s = 8'($urandom);
      if (pick < 40) begin
        // step the phase most of the time, then usually read back
        s[2] = ($urandom_range(0, 4) == 0) ? phase_q[0] : ~phase_q[0];
        send(KIND_SELECT, s, 12'($urandom), 12'($urandom));
        if ($urandom_range(0, 3) != 0) send(KIND_READ, 8'($urandom), 12'($urandom), 12'($urandom));
      end else if (pick < 55) begin
        repeat ($urandom_range(1, 6)) send(KIND_TICK, s, 12'($urandom), 12'($urandom));
      end else if (pick < 70) begin
        send(KIND_READ, s, 12'($urandom), 12'($urandom));
      end else if (pick < 82) begin
        send(KIND_BUTTON, s, 12'($urandom), 12'($urandom) & 12'($urandom));
      end else if (pick < 86) begin
        if ($urandom_range(0, 1) == 0) send(KIND_BUTTON, s, MODE_BUTTON, 12'h000);
        else send(KIND_BUTTON, s, 12'h000, MODE_BUTTON);
        send(KIND_PLUG, 8'($urandom), 12'($urandom), 12'($urandom));
      end else if (pick < 88) begin
        if (timeout_q <= 16'd40)
          repeat (int'(timeout_q) + $urandom_range(0, 2)) send(KIND_TICK, s, 12'h000, 12'h000);
        else
          send(KIND_TICK, s, 12'hfff, 12'hfff);
      end else begin
        send(3'($urandom), s, 12'($urandom), 12'($urandom));
      end
    end
  endtask

  initial begin
    pad_rows[0]  = '{KIND_READ,    8'h00, 12'h000, 12'h000, 1'b1, 6'h3f};
    pad_rows[1]  = '{KIND_BUTTON,  8'hff, 12'hfff, 12'h000, 1'b0, 6'h00};
    pad_rows[2]  = '{KIND_READ,    8'hff, 12'hfff, 12'hfff, 1'b1, 6'h00};
    pad_rows[3]  = '{KIND_SELECT,  8'h04, 12'h000, 12'h000, 1'b0, 6'h00};
    pad_rows[4]  = '{KIND_READ,    8'h00, 12'h000, 12'h000, 1'b1, 6'h00};
    pad_rows[5]  = '{KIND_SELECT,  8'h00, 12'hfff, 12'hfff, 1'b0, 6'h00};
    pad_rows[6]  = '{KIND_SELECT,  8'hff, 12'h000, 12'h000, 1'b0, 6'h00};
    pad_rows[7]  = '{KIND_READ,    8'h00, 12'h000, 12'h000, 1'b0, 6'h00};
    pad_rows[8]  = '{KIND_SELECT,  8'h00, 12'h000, 12'h000, 1'b0, 6'h00};
    pad_rows[9]  = '{KIND_SELECT,  8'h04, 12'h000, 12'h000, 1'b0, 6'h00};
    pad_rows[10] = '{KIND_READ,    8'h00, 12'h000, 12'h000, 1'b1, 6'h00};
    pad_rows[11] = '{KIND_SELECT,  8'hfb, 12'h000, 12'h000, 1'b0, 6'h00};
    pad_rows[12] = '{KIND_READ,    8'h00, 12'h000, 12'h000, 1'b1, 6'h00};
    pad_rows[13] = '{KIND_SELECT,  8'hfb, 12'h000, 12'h000, 1'b0, 6'h00};
    pad_rows[14] = '{KIND_SELECT,  8'h04, 12'h000, 12'h000, 1'b0, 6'h00};
    pad_rows[15] = '{KIND_READ,    8'h00, 12'h000, 12'h000, 1'b1, 6'h0f};
    pad_rows[16] = '{KIND_SELECT,  8'h00, 12'h000, 12'h000, 1'b0, 6'h00};
    pad_rows[17] = '{KIND_BUTTON,  8'h00, 12'h0a5, 12'hfff, 1'b0, 6'h00};
    pad_rows[18] = '{KIND_BUTTON,  8'h00, 12'h0a5, 12'h0a5, 1'b0, 6'h00};
    pad_rows[19] = '{KIND_READ,    8'h00, 12'h000, 12'h000, 1'b1, 6'h3f};
    pad_rows[20] = '{KIND_SPARE_5, 8'hff, 12'hfff, 12'h000, 1'b0, 6'h00};
    pad_rows[21] = '{KIND_SPARE_7, 8'h04, 12'hfff, 12'h000, 1'b0, 6'h00};
    pad_rows[22] = '{KIND_BUTTON,  8'h00, 12'h800, 12'h000, 1'b0, 6'h00};
    pad_rows[23] = '{KIND_PLUG,    8'h00, 12'h000, 12'h000, 1'b0, 6'h00};
    pad_rows[24] = '{KIND_SELECT,  8'h04, 12'h000, 12'h000, 1'b0, 6'h00};
    pad_rows[25] = '{KIND_READ,    8'h00, 12'h000, 12'h000, 1'b1, 6'h33};
    pad_rows[26] = '{KIND_PLUG,    8'hff, 12'hfff, 12'hfff, 1'b0, 6'h00};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      item_t it;
      it.kind = pad_rows[i].kind;
      it.select_byte = pad_rows[i].sel;
      it.press_mask = pad_rows[i].press;
      it.release_mask = pad_rows[i].rel;
      push_item(it, pad_rows[i].fixed_on, pad_rows[i].fixed_val);
    end

    set_timeout(16'd0);
    random_traffic(45);
    set_timeout(16'd1);
    random_traffic(45);
    timeout_mid = 16'($urandom_range(2, 40));
    set_timeout(timeout_mid);
    random_traffic(45);

    set_timeout(16'hffff);
    random_traffic(45);

    set_timeout(TIMEOUT_RESET);
    quiet = 1'b1;
    random_traffic(45);

    in_valid <= 1'b0;
    while (pad_words_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d items, checked %0d pad words; timeouts 0, 1, %0d, 65535 and 1500",
             items_sent, words_seen, timeout_mid);
    $display("three- and six-button plugs, spare kinds and phase timeouts exercised");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
